[rtl/ndr_pkg.sv]
// Shared types, sizes and helper functions for the nearest-neighbor downscaler.
// Used by ndr_cfg, nearest_downscale_to_rgb555 and the testbench; depends on nothing else.
`default_nettype none

package ndr_pkg;

	// Output frame and source limits.
	localparam int OUT_WIDTH = 240;
	localparam int OUT_HEIGHT = 160;
	localparam int MAX_SOURCE_SIZE = 4096;

	// Register reset values.
	localparam int SRC_WIDTH_RESET = 1920;
	localparam int SRC_HEIGHT_RESET = 1080;

	// Fixed field widths of the ports.
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CHAN_W = 8;
	localparam int COLOR_BITS = 5;
	localparam int PIX_W = 3 * COLOR_BITS;
	localparam int COORD_W = 8;

	// Derived internal widths.
	localparam int OUT_MAX = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
	localparam int OUT_MIN = (OUT_WIDTH < OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
	localparam int SIZE_W = $clog2(MAX_SOURCE_SIZE + 1);
	localparam int POS_W = $clog2(MAX_SOURCE_SIZE);
	localparam int OCNT_W = $clog2(OUT_MAX + 1);
	localparam int REM_W = $clog2(OUT_MAX);
	localparam int QUOT_W = $clog2(MAX_SOURCE_SIZE / OUT_MIN + 2);
	localparam int WIDE_W = CFG_W + SIZE_W;

	// Reciprocal constants: size * RECIP >> RECIP_SHIFT is the quotient or one less.
	localparam int RECIP_SHIFT = SIZE_W + 3;
	localparam int RECIP_W = $clog2((1 << RECIP_SHIFT) / OUT_MIN + 1);
	localparam int RECIP_WIDTH = (1 << RECIP_SHIFT) / OUT_WIDTH;
	localparam int RECIP_HEIGHT = (1 << RECIP_SHIFT) / OUT_HEIGHT;
	localparam int PROD_W = SIZE_W + RECIP_W;

	typedef logic [CFG_W-1:0] cfg_data_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [OCNT_W-1:0] ocnt_t;
	typedef logic [REM_W-1:0] rem_t;
	typedef logic [REM_W:0] rsum_t;
	typedef logic [QUOT_W-1:0] quot_t;
	typedef logic [RECIP_W-1:0] recip_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} cfg_reg_t;

	// Per-axis step: effective source size and the quotient and remainder of
	// that size over the output size.
	typedef struct packed {
		size_t size;
		quot_t quot;
		rem_t  rem;
	} axis_cfg_t;

	// Saturate a written size into [lo, MAX_SOURCE_SIZE].
	function automatic size_t clamp_size(cfg_data_t raw, size_t lo);
		size_t res;
		if (wide_t'(raw) < wide_t'(lo)) begin
			res = lo;
		end else if (wide_t'(raw) > wide_t'(MAX_SOURCE_SIZE)) begin
			res = size_t'(MAX_SOURCE_SIZE);
		end else begin
			res = size_t'(raw);
		end
		return res;
	endfunction

	// Quotient estimate by reciprocal multiplication; it is exact or one low.
	function automatic quot_t quot_estimate(size_t sz, recip_t recip);
		prod_t prod;
		prod = prod_t'(sz) * prod_t'(recip);
		return prod[RECIP_SHIFT +: QUOT_W];
	endfunction

	// Correct the estimate and form the remainder.
	function automatic axis_cfg_t axis_fix(size_t sz, quot_t qe, size_t out_size);
		size_t prodq;
		size_t r;
		axis_cfg_t res;
		prodq = size_t'(qe) * out_size;
		r = sz - prodq;
		res.size = sz;
		if (r >= out_size) begin
			res.quot = qe + quot_t'(1);
			res.rem = rem_t'(r - out_size);
		end else begin
			res.quot = qe;
			res.rem = rem_t'(r);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/ndr_cfg.sv]
// Size registers of the downscaler and the per-axis step values derived from them.
// Depends on ndr_pkg.
`default_nettype none

module ndr_cfg (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire [ndr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [ndr_pkg::CFG_W-1:0]     cfg_data,
	output ndr_pkg::axis_cfg_t      width_cfg,
	output ndr_pkg::axis_cfg_t      height_cfg
);

	ndr_pkg::size_t wclamp;
	ndr_pkg::size_t hclamp;
	ndr_pkg::size_t wsize_q;
	ndr_pkg::size_t hsize_q;
	ndr_pkg::quot_t wqest_q;
	ndr_pkg::quot_t hqest_q;
	ndr_pkg::axis_cfg_t width_cfg_q;
	ndr_pkg::axis_cfg_t height_cfg_q;

	always_comb begin
		wclamp = ndr_pkg::clamp_size(cfg_data, ndr_pkg::size_t'(ndr_pkg::OUT_WIDTH));
		hclamp = ndr_pkg::clamp_size(cfg_data, ndr_pkg::size_t'(ndr_pkg::OUT_HEIGHT));
	end

	// First step: the clamped size and the reciprocal quotient estimate are
	// captured with the write itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= ndr_pkg::clamp_size(ndr_pkg::cfg_data_t'(ndr_pkg::SRC_WIDTH_RESET),
				ndr_pkg::size_t'(ndr_pkg::OUT_WIDTH));
			hsize_q <= ndr_pkg::clamp_size(ndr_pkg::cfg_data_t'(ndr_pkg::SRC_HEIGHT_RESET),
				ndr_pkg::size_t'(ndr_pkg::OUT_HEIGHT));
			wqest_q <= ndr_pkg::quot_t'(ndr_pkg::SRC_WIDTH_RESET / ndr_pkg::OUT_WIDTH);
			hqest_q <= ndr_pkg::quot_t'(ndr_pkg::SRC_HEIGHT_RESET / ndr_pkg::OUT_HEIGHT);
		end else if (cfg_we) begin
			case (ndr_pkg::cfg_reg_t'(cfg_index))
				ndr_pkg::REG_SRC_WIDTH: begin
					wsize_q <= wclamp;
					wqest_q <= ndr_pkg::quot_estimate(wclamp,
						ndr_pkg::recip_t'(ndr_pkg::RECIP_WIDTH));
				end
				ndr_pkg::REG_SRC_HEIGHT: begin
					hsize_q <= hclamp;
					hqest_q <= ndr_pkg::quot_estimate(hclamp,
						ndr_pkg::recip_t'(ndr_pkg::RECIP_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	// Second step: correct the estimate and form the remainder from the first-step registers.
	// The reset value is built from the reset sizes alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q <= ndr_pkg::axis_fix(
				ndr_pkg::clamp_size(ndr_pkg::cfg_data_t'(ndr_pkg::SRC_WIDTH_RESET),
					ndr_pkg::size_t'(ndr_pkg::OUT_WIDTH)),
				ndr_pkg::quot_t'(ndr_pkg::SRC_WIDTH_RESET / ndr_pkg::OUT_WIDTH),
				ndr_pkg::size_t'(ndr_pkg::OUT_WIDTH));
			height_cfg_q <= ndr_pkg::axis_fix(
				ndr_pkg::clamp_size(ndr_pkg::cfg_data_t'(ndr_pkg::SRC_HEIGHT_RESET),
					ndr_pkg::size_t'(ndr_pkg::OUT_HEIGHT)),
				ndr_pkg::quot_t'(ndr_pkg::SRC_HEIGHT_RESET / ndr_pkg::OUT_HEIGHT),
				ndr_pkg::size_t'(ndr_pkg::OUT_HEIGHT));
		end else begin
			width_cfg_q <= ndr_pkg::axis_fix(wsize_q, wqest_q,
				ndr_pkg::size_t'(ndr_pkg::OUT_WIDTH));
			height_cfg_q <= ndr_pkg::axis_fix(hsize_q, hqest_q,
				ndr_pkg::size_t'(ndr_pkg::OUT_HEIGHT));
		end
	end

	assign width_cfg = width_cfg_q;
	assign height_cfg = height_cfg_q;

endmodule

`default_nettype wire

[rtl/nearest_downscale_to_rgb555.sv]
// Nearest-neighbor downscaler from a raster pixel stream to 240x160 RGB 5:5:5.
// A source pixel is accepted on every transfer of the input channel into the
// input register, from where it is either dropped or placed in the output register
// together with its output column, row and an end-of-frame flag. The block sustains
// one pixel per clock: there is a single input register, the selection logic and
// an output register, and a new pixel is taken while a finished one waits. The only
// stall is a selected pixel that meets a full output register whose result is
// not being taken. Source sizes are written through cfg_we/cfg_index/cfg_data and
// are saturated to at least the output size and at most 4096; the derived step
// values pass through the first-step and second-step registers of ndr_cfg, in time
// for a pixel transferred at the next edge after the write. A frame_start pixel
// clears all position counters before it is used; a frame also wraps on its own
// after its last row. Depends on ndr_pkg and ndr_cfg.
`default_nettype none

module nearest_downscale_to_rgb555 (
	input  wire                          clk,
	input  wire                          arst_n,
	// Size register write port.
	input  wire                          cfg_we,
	input  wire [ndr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [ndr_pkg::CFG_W-1:0]     cfg_data,
	// Source pixel channel.
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [ndr_pkg::CHAN_W-1:0]    chan_first,
	input  wire [ndr_pkg::CHAN_W-1:0]    chan_second,
	input  wire [ndr_pkg::CHAN_W-1:0]    chan_third,
	input  wire                          frame_start,
	// Output pixel channel.
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [ndr_pkg::PIX_W-1:0]    pixel_555,
	output logic [ndr_pkg::COORD_W-1:0]  out_col,
	output logic [ndr_pkg::COORD_W-1:0]  out_row,
	output logic                         frame_last
);

	ndr_pkg::axis_cfg_t width_cfg;
	ndr_pkg::axis_cfg_t height_cfg;

	ndr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.width_cfg  (width_cfg),
		.height_cfg (height_cfg)
	);

	// Input register.
	logic           valid_s1;
	ndr_pkg::chan_t c1_s1;
	ndr_pkg::chan_t c2_s1;
	ndr_pkg::chan_t c3_s1;
	logic           fs_s1;

	// Position state.
	ndr_pkg::pos_t  src_col_q;
	ndr_pkg::pos_t  src_row_q;
	ndr_pkg::ocnt_t out_col_q;
	ndr_pkg::ocnt_t out_row_q;
	ndr_pkg::size_t chosen_col_q;
	ndr_pkg::rem_t  col_rem_q;
	ndr_pkg::size_t chosen_row_q;
	ndr_pkg::rem_t  row_rem_q;

	// Output register.
	logic           out_valid_q;
	ndr_pkg::pix_t  pix_q;
	ndr_pkg::coord_t ocol_q;
	ndr_pkg::coord_t orow_q;
	logic           last_q;

	// Position state as seen by the pixel in the input register; a frame start
	// clears it first.
	ndr_pkg::pos_t  cur_src_col;
	ndr_pkg::pos_t  cur_src_row;
	ndr_pkg::ocnt_t cur_out_col;
	ndr_pkg::ocnt_t cur_out_row;
	ndr_pkg::size_t cur_chosen_col;
	ndr_pkg::rem_t  cur_col_rem;
	ndr_pkg::size_t cur_chosen_row;
	ndr_pkg::rem_t  cur_row_rem;

	logic           row_hit;
	logic           hit;
	logic           out_free;
	logic           advance;
	ndr_pkg::rsum_t col_rsum;
	ndr_pkg::rsum_t row_rsum;
	ndr_pkg::size_t src_col_inc;
	ndr_pkg::size_t src_row_inc;
	logic           row_end;
	logic           frame_end;

	ndr_pkg::pos_t  nxt_src_col;
	ndr_pkg::pos_t  nxt_src_row;
	ndr_pkg::ocnt_t nxt_out_col;
	ndr_pkg::ocnt_t nxt_out_row;
	ndr_pkg::size_t nxt_chosen_col;
	ndr_pkg::rem_t  nxt_col_rem;
	ndr_pkg::size_t nxt_chosen_row;
	ndr_pkg::rem_t  nxt_row_rem;

	always_comb begin
		if (fs_s1) begin
			cur_src_col = '0;
			cur_src_row = '0;
			cur_out_col = '0;
			cur_out_row = '0;
			cur_chosen_col = '0;
			cur_col_rem = '0;
			cur_chosen_row = '0;
			cur_row_rem = '0;
		end else begin
			cur_src_col = src_col_q;
			cur_src_row = src_row_q;
			cur_out_col = out_col_q;
			cur_out_row = out_row_q;
			cur_chosen_col = chosen_col_q;
			cur_col_rem = col_rem_q;
			cur_chosen_row = chosen_row_q;
			cur_row_rem = row_rem_q;
		end
	end

	// The pixel is chosen when both selectors point at it and the output frame
	// still has room on that axis.
	always_comb begin
		row_hit = (cur_out_row < ndr_pkg::ocnt_t'(ndr_pkg::OUT_HEIGHT)) &&
			(ndr_pkg::size_t'(cur_src_row) == cur_chosen_row);
		hit = row_hit && (cur_out_col < ndr_pkg::ocnt_t'(ndr_pkg::OUT_WIDTH)) &&
			(ndr_pkg::size_t'(cur_src_col) == cur_chosen_col);
	end

	// A dropped pixel never waits on the output side.
	assign out_free = !out_valid_q || out_ready;
	assign advance = valid_s1 && (!hit || out_free);
	assign in_ready = !valid_s1 || advance;

	// Selector and counter updates.
	always_comb begin
		col_rsum = ndr_pkg::rsum_t'(cur_col_rem) + ndr_pkg::rsum_t'(width_cfg.rem);
		row_rsum = ndr_pkg::rsum_t'(cur_row_rem) + ndr_pkg::rsum_t'(height_cfg.rem);
		src_col_inc = ndr_pkg::size_t'(cur_src_col) + ndr_pkg::size_t'(1);
		src_row_inc = ndr_pkg::size_t'(cur_src_row) + ndr_pkg::size_t'(1);
		row_end = (src_col_inc >= width_cfg.size);
		frame_end = (src_row_inc >= height_cfg.size);

		nxt_src_col = ndr_pkg::pos_t'(src_col_inc);
		nxt_src_row = cur_src_row;
		nxt_out_col = cur_out_col;
		nxt_out_row = cur_out_row;
		nxt_chosen_col = cur_chosen_col;
		nxt_col_rem = cur_col_rem;
		nxt_chosen_row = cur_chosen_row;
		nxt_row_rem = cur_row_rem;

		if (hit) begin
			nxt_out_col = cur_out_col + ndr_pkg::ocnt_t'(1);
			if (col_rsum >= ndr_pkg::rsum_t'(ndr_pkg::OUT_WIDTH)) begin
				nxt_chosen_col = cur_chosen_col + ndr_pkg::size_t'(width_cfg.quot) +
					ndr_pkg::size_t'(1);
				nxt_col_rem = ndr_pkg::rem_t'(col_rsum - ndr_pkg::rsum_t'(ndr_pkg::OUT_WIDTH));
			end else begin
				nxt_chosen_col = cur_chosen_col + ndr_pkg::size_t'(width_cfg.quot);
				nxt_col_rem = ndr_pkg::rem_t'(col_rsum);
			end
		end

		if (row_end) begin
			nxt_src_col = '0;
			nxt_out_col = '0;
			nxt_chosen_col = '0;
			nxt_col_rem = '0;
			if (row_hit) begin
				nxt_out_row = cur_out_row + ndr_pkg::ocnt_t'(1);
				if (row_rsum >= ndr_pkg::rsum_t'(ndr_pkg::OUT_HEIGHT)) begin
					nxt_chosen_row = cur_chosen_row + ndr_pkg::size_t'(height_cfg.quot) +
						ndr_pkg::size_t'(1);
					nxt_row_rem = ndr_pkg::rem_t'(row_rsum -
						ndr_pkg::rsum_t'(ndr_pkg::OUT_HEIGHT));
				end else begin
					nxt_chosen_row = cur_chosen_row + ndr_pkg::size_t'(height_cfg.quot);
					nxt_row_rem = ndr_pkg::rem_t'(row_rsum);
				end
			end
			// After the last source row the frame wraps and the row selector restarts.
			if (frame_end) begin
				nxt_src_row = '0;
				nxt_out_row = '0;
				nxt_chosen_row = '0;
				nxt_row_rem = '0;
			end else begin
				nxt_src_row = ndr_pkg::pos_t'(src_row_inc);
			end
		end
	end

	// Input register: loads on every input transfer, empties when the pixel
	// has been dealt with.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c1_s1 <= chan_first;
			c2_s1 <= chan_second;
			c3_s1 <= chan_third;
			fs_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			chosen_col_q <= '0;
			col_rem_q <= '0;
			chosen_row_q <= '0;
			row_rem_q <= '0;
		end else if (advance) begin
			src_col_q <= nxt_src_col;
			src_row_q <= nxt_src_row;
			out_col_q <= nxt_out_col;
			out_row_q <= nxt_out_row;
			chosen_col_q <= nxt_chosen_col;
			col_rem_q <= nxt_col_rem;
			chosen_row_q <= nxt_chosen_row;
			row_rem_q <= nxt_row_rem;
		end
	end

	// Output register: a chosen pixel is written when it advances; otherwise the
	// register empties once its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			pix_q <= {c1_s1[ndr_pkg::CHAN_W-1 -: ndr_pkg::COLOR_BITS],
				c2_s1[ndr_pkg::CHAN_W-1 -: ndr_pkg::COLOR_BITS],
				c3_s1[ndr_pkg::CHAN_W-1 -: ndr_pkg::COLOR_BITS]};
			ocol_q <= ndr_pkg::coord_t'(cur_out_col);
			orow_q <= ndr_pkg::coord_t'(cur_out_row);
			last_q <= (cur_out_col == ndr_pkg::ocnt_t'(ndr_pkg::OUT_WIDTH - 1)) &&
				(cur_out_row == ndr_pkg::ocnt_t'(ndr_pkg::OUT_HEIGHT - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_555 = pix_q;
	assign out_col = ocol_q;
	assign out_row = orow_q;
	assign frame_last = last_q;

endmodule

`default_nettype wire

[tb/nearest_downscale_to_rgb555_test.sv]
// Self-checking testbench for the nearest-neighbor downscaler to 240x160 RGB 5:5:5.
// Depends on ndr_pkg and nearest_downscale_to_rgb555; it predicts every output pixel
// from the source stream it sends and compares each output transfer field by field.
`timescale 1ns / 100ps

module nearest_downscale_to_rgb555_test;

	import ndr_pkg::*;

	// One expected output pixel, with the same fields as the output channel.
	typedef struct packed {
		pix_t   pixel;
		coord_t col;
		coord_t row;
		logic   last;
	} scaled_pixel_t;

	// Colour bytes that hit the truncation boundaries of the 5-bit packing.
	localparam logic [7:0] COLOR_PATTERNS [8] = '{
		8'hFF, 8'h00, 8'hF8, 8'h07, 8'hAA, 8'h55, 8'h80, 8'h7F
	};

	// Cycles to let pass after the last expected pixel, so that dropped pixels
	// still inside the pipeline have left it before a size register changes.
	localparam int DRAIN_CYCLES = 8;
	// The size register feeds derived step values that settle in the registers of ndr_cfg.
	localparam int SETTLE_CYCLES = 3;
	// Length of the receiver hold-off that fills the block and stalls the input.
	localparam int HOLD_OFF_CYCLES = 200;
	// Idle probability of each side, in percent.
	localparam int IDLE_PCT = 32;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_reg_t  cfg_index;
	cfg_data_t cfg_data;
	logic      in_valid;
	logic      in_ready;
	chan_t     chan_first;
	chan_t     chan_second;
	chan_t     chan_third;
	logic      frame_start;
	logic      out_valid;
	logic      out_ready;
	pix_t      pixel_555;
	coord_t    out_col;
	coord_t    out_row;
	logic      frame_last;

	nearest_downscale_to_rgb555 DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.chan_first  (chan_first),
		.chan_second (chan_second),
		.chan_third  (chan_third),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_555   (pixel_555),
		.out_col     (out_col),
		.out_row     (out_row),
		.frame_last  (frame_last)
	);

	// Predictor copy of the size registers, as written through the port.
	cfg_data_t width_reg = cfg_data_t'(SRC_WIDTH_RESET);
	cfg_data_t height_reg = cfg_data_t'(SRC_HEIGHT_RESET);

	// Predictor copy of the position counters and the per-axis selectors.
	// Positions are kept one bit wider than a 4096 count so that the end-of-row
	// compare never sees a wrapped value.
	logic [13:0] src_col = '0;
	logic [13:0] src_row = '0;
	logic [7:0]  dst_col = '0;
	logic [7:0]  dst_row = '0;
	logic [13:0] pick_col = '0;
	logic [8:0]  pick_col_frac = '0;
	logic [13:0] pick_row = '0;
	logic [8:0]  pick_row_frac = '0;

	scaled_pixel_t expected_pixels [$];
	scaled_pixel_t head_pixel;

	int  mismatches = 0;
	int  pixels_sent = 0;
	int  pixels_checked = 0;
	int  frame_ends = 0;
	// Set by the tests: no idling on either side while high.
	bit  steady = 0;
	// Receiver hold-off, counted down by the receiver process itself.
	int  hold_cycles = 0;

	// Clock: 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, far above the slowest correct run of this stimulus.
	initial begin
		#10ms;
		$display("timeout at %0t with %0d output pixels still expected", $time,
			expected_pixels.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Saturates a size register into the range the block accepts. Both axes
	// share the upper bound; only the lower bound differs.
	function automatic logic [13:0] usable_size(cfg_data_t raw, int floor_size);
		int v;
		v = int'(raw);
		if (v < floor_size)
			v = floor_size;
		if (v > MAX_SOURCE_SIZE)
			v = MAX_SOURCE_SIZE;
		return 14'(v);
	endfunction

	// Advances the predictor by one source pixel and queues the output pixel
	// it selects, if any.
	function automatic void select_pixel(chan_t c1, chan_t c2, chan_t c3, logic fs);
		logic [13:0]   w;
		logic [13:0]   h;
		logic          row_on;
		scaled_pixel_t px;
		w = usable_size(width_reg, OUT_WIDTH);
		h = usable_size(height_reg, OUT_HEIGHT);
		// A frame start clears everything before the pixel itself is used.
		if (fs) begin
			src_col = '0;
			src_row = '0;
			dst_col = '0;
			dst_row = '0;
			pick_col = '0;
			pick_col_frac = '0;
			pick_row = '0;
			pick_row_frac = '0;
		end
		row_on = (dst_row < OUT_HEIGHT) && (src_row == pick_row);
		if (row_on && dst_col < OUT_WIDTH && src_col == pick_col) begin
			px.pixel = {c1[7:3], c2[7:3], c3[7:3]};
			px.col = dst_col;
			px.row = dst_row;
			px.last = (dst_col == OUT_WIDTH - 1) && (dst_row == OUT_HEIGHT - 1);
			expected_pixels.push_back(px);
			// Next chosen column is floor(k*w/OUT_WIDTH), kept as quotient and remainder.
			dst_col = dst_col + 8'd1;
			pick_col = pick_col + 14'(w / OUT_WIDTH);
			pick_col_frac = pick_col_frac + 9'(w % OUT_WIDTH);
			if (pick_col_frac >= OUT_WIDTH) begin
				pick_col_frac = pick_col_frac - 9'(OUT_WIDTH);
				pick_col = pick_col + 14'd1;
			end
		end
		src_col = src_col + 14'd1;
		// A column at or past the width ends the row, even after a shrinking write.
		if (src_col >= w) begin
			src_col = '0;
			dst_col = '0;
			pick_col = '0;
			pick_col_frac = '0;
			if (row_on) begin
				dst_row = dst_row + 8'd1;
				pick_row = pick_row + 14'(h / OUT_HEIGHT);
				pick_row_frac = pick_row_frac + 9'(h % OUT_HEIGHT);
				if (pick_row_frac >= OUT_HEIGHT) begin
					pick_row_frac = pick_row_frac - 9'(OUT_HEIGHT);
					pick_row = pick_row + 14'd1;
				end
			end
			src_row = src_row + 14'd1;
			// Past the last row the frame wraps on its own.
			if (src_row >= h) begin
				src_row = '0;
				dst_row = '0;
				pick_row = '0;
				pick_row_frac = '0;
			end
		end
	endfunction

	// Receiver: ready is driven at the falling edge. A pending hold-off wins,
	// then a steady stretch, otherwise ready drops in about a third of cycles.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles = hold_cycles - 1;
			end else if (steady) begin
				out_ready = 1'b1;
			end else begin
				out_ready = ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Checker: every output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: output pixel with none expected: pixel %h col %0d row %0d last %b",
					$time, pixel_555, out_col, out_row, frame_last);
				mismatches++;
			end else begin
				head_pixel = expected_pixels.pop_front();
				pixels_checked++;
				if (frame_last)
					frame_ends++;
				if (pixel_555 !== head_pixel.pixel) begin
					$display("%0t: pixel_555 expected %h actual %h", $time,
						head_pixel.pixel, pixel_555);
					mismatches++;
				end
				if (out_col !== head_pixel.col) begin
					$display("%0t: out_col expected %0d actual %0d", $time,
						head_pixel.col, out_col);
					mismatches++;
				end
				if (out_row !== head_pixel.row) begin
					$display("%0t: out_row expected %0d actual %0d", $time,
						head_pixel.row, out_row);
					mismatches++;
				end
				if (frame_last !== head_pixel.last) begin
					$display("%0t: frame_last expected %b actual %b", $time,
						head_pixel.last, frame_last);
					mismatches++;
				end
			end
		end
	end

	// Offers one source pixel and returns after its transfer. It is entered and
	// left at a falling edge; valid stays high with a fixed payload until the
	// rising edge at which in_ready is seen high.
	task automatic send_pixel(chan_t c1, chan_t c2, chan_t c3, logic fs);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		chan_first = c1;
		chan_second = c2;
		chan_third = c3;
		frame_start = fs;
		do
			@(posedge clk);
		while (!in_ready);
		select_pixel(c1, c2, c3, fs);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Sends a run of random pixels. The first one carries the given frame start;
	// the rest carry a stray frame start with the given probability in percent.
	task automatic send_stream(int count, logic first_fs, int restart_pct);
		for (int i = 0; i < count; i++)
			send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
				(i == 0) ? first_fs : ($urandom_range(99) < restart_pct));
	endtask

	// Waits until every expected pixel has arrived and the pipeline has emptied.
	task automatic drain;
		in_valid = 1'b0;
		frame_start = 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes a size register while the block is idle, then lets the derived
	// step values settle before any pixel is offered.
	task automatic write_size(cfg_reg_t idx, cfg_data_t value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_SRC_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Reset sizes of 1920x1080: every eighth column of row zero is chosen.
	// The colour patterns put set and clear bits on both sides of the cut
	// between the kept top five bits and the dropped low three.
	task automatic test_reset_sizes;
		for (int i = 0; i < 24; i++)
			send_pixel(COLOR_PATTERNS[(i + i / 8) % 8], COLOR_PATTERNS[(i + 3 + i / 8) % 8],
				COLOR_PATTERNS[(i + 5 + i / 8) % 8], i == 0);
		drain();
	endtask

	// Sizes outside the supported range saturate: zero becomes the output size
	// and anything above 4096 becomes 4096. A frame start in the middle of a
	// row must restart at output column zero.
	task automatic test_size_saturation;
		write_size(REG_SRC_WIDTH, cfg_data_t'(0));
		write_size(REG_SRC_HEIGHT, '1);
		send_stream(12, 1'b1, 0);
		drain();
		write_size(REG_SRC_WIDTH, '1);
		write_size(REG_SRC_HEIGHT, cfg_data_t'(0));
		send_stream(20, 1'b1, 0);
		send_stream(6, 1'b1, 0);
		drain();
	endtask

	// Source size equal to the output size, where every source pixel is kept.
	// The receiver first holds off long enough to fill the block and stall its
	// input, and one stretch runs with no idling on either side.
	task automatic test_exact_size;
		write_size(REG_SRC_WIDTH, cfg_data_t'(OUT_WIDTH));
		write_size(REG_SRC_HEIGHT, cfg_data_t'(OUT_HEIGHT));
		hold_cycles = HOLD_OFF_CYCLES;
		send_stream(30, 1'b1, 0);
		steady = 1'b1;
		send_stream(50, 1'b0, 0);
		steady = 1'b0;
		send_stream(20, 1'b0, 0);
		drain();
	endtask

	// A width with a remainder: the column selector must carry the remainder
	// into an extra source column every twelfth output pixel. The height also
	// leaves a remainder, but the stream ends before the first source row does.
	task automatic test_selector_remainders;
		write_size(REG_SRC_WIDTH, cfg_data_t'(260));
		write_size(REG_SRC_HEIGHT, cfg_data_t'(319));
		send_stream(245, 1'b1, 0);
		drain();
	endtask

	// A size write between transfers in the middle of a row. The counters keep
	// their values; the source column, already beyond the smaller width, is
	// still chosen and then ends the row at once, and the next row follows.
	task automatic test_resize_mid_frame;
		write_size(REG_SRC_WIDTH, cfg_data_t'(OUT_WIDTH));
		send_stream(15, 1'b0, 0);
		drain();
	endtask

	// The widest source rows the block takes: 4096 columns.
	task automatic test_widest_rows;
		write_size(REG_SRC_WIDTH, cfg_data_t'(MAX_SOURCE_SIZE));
		write_size(REG_SRC_HEIGHT, cfg_data_t'(MAX_SOURCE_SIZE));
		send_stream(60, 1'b1, 0);
		drain();
	endtask

	// Random sizes, mostly small so that many output pixels come, now and then
	// out of range, each followed by a short run of random pixels with an
	// occasional stray frame start.
	task automatic test_random_frames;
		cfg_data_t w;
		cfg_data_t h;
		for (int phase = 0; phase < 4; phase++) begin
			case ($urandom_range(9))
				0: w = cfg_data_t'($urandom);
				1: w = cfg_data_t'($urandom_range(OUT_WIDTH - 1));
				2: w = cfg_data_t'($urandom_range(1000, 321));
				default: w = cfg_data_t'($urandom_range(320, OUT_WIDTH));
			endcase
			case ($urandom_range(9))
				0: h = cfg_data_t'($urandom);
				1: h = cfg_data_t'($urandom_range(OUT_HEIGHT - 1));
				default: h = cfg_data_t'($urandom_range(200, OUT_HEIGHT));
			endcase
			write_size(REG_SRC_WIDTH, w);
			write_size(REG_SRC_HEIGHT, h);
			send_stream($urandom_range(40, 20), 1'b1, 5);
			drain();
		end
	endtask

	// Test sequence. Reset is held from time zero and released at a falling edge;
	// all block inputs are known from time zero.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		chan_first = '0;
		chan_second = '0;
		chan_third = '0;
		frame_start = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_sizes();
		test_size_saturation();
		test_exact_size();
		test_selector_remainders();
		test_resize_mid_frame();
		test_widest_rows();
		test_random_frames();
		drain();

		$display("sent %0d source pixels over saturated, exact, remainder and resized sizes",
			pixels_sent);
		$display("checked %0d output pixels, %0d of them marked last of frame",
			pixels_checked, frame_ends);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
rtl/ndr_pkg.sv
rtl/ndr_cfg.sv
rtl/nearest_downscale_to_rgb555.sv
tb/nearest_downscale_to_rgb555_test.sv
